/* sv/rsp_pkg.sv */
// Shared types and constants for the radix string to unsigned parser.
package rsp_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int WIDE_WIDTH  = VALUE_WIDTH + 5;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_FMT = 2'd1;
    localparam logic [1:0] STATUS_OVF = 2'd2;
    localparam logic [1:0] STATUS_ARG = 2'd3;

    localparam logic [4:0] RADIX_NONE = 5'd0;
    localparam logic [4:0] RADIX_BIN  = 5'd2;
    localparam logic [4:0] RADIX_OCT  = 5'd8;
    localparam logic [4:0] RADIX_DEC  = 5'd10;
    localparam logic [4:0] RADIX_HEX  = 5'd16;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_REST   = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_B  = 8'h62;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_LO_X  = 8'h78;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;

    typedef struct packed {
        logic [7:0] char_code;
        logic [4:0] radix;
        logic       last_char;
    } rsp_in_t;

    typedef struct packed {
        logic [63:0] parsed_value;
        logic [1:0]  status;
    } rsp_out_t;

    typedef struct packed {
        logic                   digit_ok;
        logic                   overflow;
        logic [VALUE_WIDTH-1:0] next_acc;
    } rsp_mac_t;

endpackage

/* sv/rsp_in_reg.sv */
// Input word register with its valid flag and upstream handshake.
module rsp_in_reg
    import rsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    src_valid,
    output logic    src_ready,
    input  rsp_in_t src_word,
    input  logic    advance,
    output logic    held_valid,
    output rsp_in_t held_word
);

    logic    vld_reg;
    rsp_in_t word_reg;

    assign src_ready  = !vld_reg || advance;
    assign held_valid = vld_reg;
    assign held_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (src_valid && src_ready)
        begin
            vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
        begin
            word_reg <= src_word;
        end
    end

endmodule

/* sv/rsp_mac.sv */
// Digit decode and value * radix + digit with overflow detection.
module rsp_mac
    import rsp_pkg::*;
(
    input  logic [VALUE_WIDTH-1:0] acc,
    input  logic [7:0]             char_code,
    input  logic [4:0]             radix,
    output rsp_mac_t               mac
);

    logic                  found;
    logic [7:0]            diff;
    logic [3:0]            digit;
    logic [WIDE_WIDTH-1:0] ext;
    logic [WIDE_WIDTH-1:0] prod;
    logic [WIDE_WIDTH-1:0] sum;

    always_comb
    begin
        found = 1'b0;
        diff  = 8'd0;
        if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)
        begin
            found = 1'b1;
            diff  = char_code - CHAR_ZERO;
        end
        else if (radix == RADIX_HEX && char_code >= CHAR_LO_A && char_code <= CHAR_LO_F)
        begin
            found = 1'b1;
            diff  = char_code - CHAR_LO_A + 8'd10;
        end
        else if (radix == RADIX_HEX && char_code >= CHAR_UP_A && char_code <= CHAR_UP_F)
        begin
            found = 1'b1;
            diff  = char_code - CHAR_UP_A + 8'd10;
        end
        digit = diff[3:0];
    end

    // Multiplying by a constant radix is a shift, or two shifts and an add for ten.
    always_comb
    begin
        ext = WIDE_WIDTH'(acc);
        case (radix)
            RADIX_BIN: prod = ext << 1;
            RADIX_OCT: prod = ext << 3;
            RADIX_HEX: prod = ext << 4;
            default:   prod = (ext << 3) + (ext << 1);
        endcase
        sum = prod + WIDE_WIDTH'(digit);
    end

    assign mac.digit_ok = found && ({1'b0, digit} < radix);
    assign mac.overflow = |sum[WIDE_WIDTH-1:VALUE_WIDTH];
    assign mac.next_acc = sum[VALUE_WIDTH-1:0];

endmodule

/* sv/radix_string_to_unsigned_parser.sv */
// Top level of the multi-radix ASCII string to unsigned integer parser.
//
// Usage: the source channel (src_valid/src_ready/src_word) carries one ASCII
// character per word, with the radix (2, 8, 10 or 16) sampled on the first
// character of a string and last_char marking its final character. Hex
// strings need the prefix "0x", octal "0", binary "b"; decimal has none.
// The result channel (res_valid/res_ready/res_word) carries one word per
// string, issued for the character marked last: the value and a status
// (success, bad format, overflow, argument error). The value is zero
// unless the status is success.
// Throughput is one character per cycle while the receiver does not stall.
// A word lands in the input register on the edge it is accepted and is
// folded into the accumulator when it advances out of that register; the
// last character then also loads the result register and sets res_valid.
// The accumulate is one shift-add by the constant radix and a compare on
// the carry bits.
// Reset clears the input and result valid flags and returns the parser to
// the start of a string. While the receiver stalls, the result register
// holds, the input register fills, and then src_ready drops.
module radix_string_to_unsigned_parser
    import rsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_ready,
    input  rsp_in_t  src_word,
    output logic     res_valid,
    input  logic     res_ready,
    output rsp_out_t res_word
);

    logic                   held_valid;
    rsp_in_t                held_word;
    logic                   advance;

    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic [1:0]             err_reg;
    logic [1:0]             err_next;
    logic [1:0]             pos_reg;
    logic [1:0]             pos_next;
    logic [4:0]             radix_reg;
    logic [4:0]             radix_next;

    logic [VALUE_WIDTH-1:0] acc_base;
    logic [1:0]             err_base;
    rsp_mac_t               mac;

    logic                   res_vld_reg;
    rsp_out_t               res_word_reg;
    rsp_out_t               res_word_next;

    rsp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .src_word   (src_word),
        .advance    (advance),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    assign advance = held_valid && (!res_vld_reg || res_ready);

    // The first character of a string starts from a clean slate.
    always_comb
    begin
        if (pos_reg == POS_FIRST)
        begin
            radix_next = held_word.radix;
            acc_base   = '0;
            if (held_word.radix == RADIX_NONE)
            begin
                err_base = STATUS_ARG;
            end
            else if (held_word.radix inside {RADIX_BIN, RADIX_OCT, RADIX_DEC, RADIX_HEX})
            begin
                err_base = STATUS_OK;
            end
            else
            begin
                err_base = STATUS_FMT;
            end
        end
        else
        begin
            radix_next = radix_reg;
            acc_base   = acc_reg;
            err_base   = err_reg;
        end
    end

    rsp_mac u_mac (
        .acc       (acc_base),
        .char_code (held_word.char_code),
        .radix     (radix_next),
        .mac       (mac)
    );

    always_comb
    begin
        logic do_acc;
        do_acc   = 1'b0;
        acc_next = acc_base;
        err_next = err_base;
        if (err_base == STATUS_OK)
        begin
            case (radix_next)
                RADIX_HEX:
                begin
                    if (pos_reg == POS_FIRST)
                    begin
                        if (held_word.char_code != CHAR_ZERO || held_word.last_char)
                        begin
                            err_next = STATUS_FMT;
                        end
                    end
                    else if (pos_reg == POS_SECOND)
                    begin
                        if (held_word.char_code != CHAR_LO_X)
                        begin
                            err_next = STATUS_FMT;
                        end
                    end
                    else
                    begin
                        do_acc = 1'b1;
                    end
                end
                RADIX_OCT, RADIX_BIN:
                begin
                    if (pos_reg == POS_FIRST)
                    begin
                        if (held_word.char_code !=
                            ((radix_next == RADIX_OCT) ? CHAR_ZERO : CHAR_LO_B))
                        begin
                            err_next = STATUS_FMT;
                        end
                    end
                    else
                    begin
                        do_acc = 1'b1;
                    end
                end
                default:
                begin
                    do_acc = 1'b1;
                end
            endcase
            if (do_acc)
            begin
                if (!mac.digit_ok)
                begin
                    err_next = STATUS_FMT;
                end
                else if (mac.overflow)
                begin
                    err_next = STATUS_OVF;
                end
                else
                begin
                    acc_next = mac.next_acc;
                end
            end
        end

        if (held_word.last_char)
        begin
            pos_next = POS_FIRST;
        end
        else if (pos_reg == POS_FIRST)
        begin
            pos_next = POS_SECOND;
        end
        else
        begin
            pos_next = POS_REST;
        end

        res_word_next.parsed_value = (err_next == STATUS_OK) ? 64'(acc_next) : 64'd0;
        res_word_next.status       = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_FIRST;
            err_reg   <= STATUS_OK;
            acc_reg   <= '0;
            radix_reg <= RADIX_NONE;
        end
        else if (advance)
        begin
            pos_reg   <= pos_next;
            err_reg   <= err_next;
            acc_reg   <= acc_next;
            radix_reg <= radix_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance && held_word.last_char)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && held_word.last_char)
        begin
            res_word_reg <= res_word_next;
        end
    end

    assign res_valid = res_vld_reg;
    assign res_word  = res_word_reg;

    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_word_reg.status != STATUS_OK |-> res_word_reg.parsed_value == 64'd0)
        else $error("result carries a nonzero value with an error status");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && held_word.last_char |=> pos_reg == POS_FIRST && res_vld_reg)
        else $error("last character did not restart the string and issue a result");

    a_arg_err_radix: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != POS_FIRST && err_reg == STATUS_ARG |-> radix_reg == RADIX_NONE)
        else $error("argument error latched with a nonzero radix");

    a_held_until_moved: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid && !advance |=> held_valid && $stable(held_word))
        else $error("input register dropped a word that was not consumed");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && !res_ready |-> !advance)
        else $error("pipeline advanced while the result register was stalled");

endmodule
